[rtl/core/timestamped_sample_fifo_top_defines.svh]
// ----------------------------------------------------------------------------
// Timestamped sample FIFO - assertion macros
// Shared property wrappers; all checks run on clk and are held off during rst.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_SAMPLE_FIFO_TOP_DEFINES_SVH
`define TIMESTAMPED_SAMPLE_FIFO_TOP_DEFINES_SVH

// Same-cycle implication
`define TSF_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TSF_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tsf_pkg.sv]
// ----------------------------------------------------------------------------
// Timestamped sample FIFO - package
// Payload structs, command and status codes, default sizes.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int MAX_READ_DEF = 64;

  localparam logic [31:0] PERIOD_RESET = 32'd89478;

  // Command kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [1:0] STAT_DROPPED  = 2'd1;
  localparam logic [1:0] STAT_SAMPLE   = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] block_count;
    logic [63:0] start_time;
    logic [31:0] sample_value;
    logic [6:0]  read_max;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] sample_out;
    logic [63:0] sample_time;
    logic        last;
    logic [10:0] available;
    logic [31:0] dropped_total;
    logic [15:0] last_block_size;
  } out_item_t;

  // Result control from the controller to the output formatter
  typedef struct packed {
    logic       strobe;
    logic       from_ram;
    logic [1:0] status;
    logic       last;
  } resp_t;

endpackage

[rtl/core/tsf_ram.sv]
// ----------------------------------------------------------------------------
// Timestamped sample FIFO - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = tsf_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/tsf_ctrl.sv]
// ----------------------------------------------------------------------------
// Timestamped sample FIFO - controller
// Pointers, block admission, time stamping and the read sequencer.
// ----------------------------------------------------------------------------
`include "timestamped_sample_fifo_top_defines.svh"

module tsf_ctrl #(
  parameter int CAPACITY = tsf_pkg::CAPACITY_DEF,
  parameter int MAX_READ = tsf_pkg::MAX_READ_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int PW = $clog2(2 * CAPACITY)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tsf_pkg::in_item_t cmd,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [31:0]       wr_value,
  output logic [63:0]       wr_time,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  output tsf_pkg::resp_t    resp,
  output logic [10:0]       avail,
  output logic [31:0]       dropped_total,
  output logic [15:0]       last_block_size
);

  localparam int SPAN = 2 * CAPACITY;
  localparam int CW   = (PW > 16) ? PW : 16;
  localparam int NW   = (PW > 7) ? PW : 7;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t        state;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] cm_ptr;
  logic [PW-1:0] rd_ptr;
  logic [15:0]   blk_left;
  logic          blk_drop;
  logic [63:0]   run_time;
  logic [31:0]   drop_cnt;
  logic [15:0]   blk_size;
  logic [31:0]   period;
  logic [6:0]    rd_left;
  logic [PW-1:0] rd_avail;

  logic          accept;
  logic [PW-1:0] occ;
  logic [PW-1:0] space;
  logic          too_big;
  logic [32:0]   drop_sum;
  logic [31:0]   drop_next;
  logic [63:0]   run_time_next;
  logic [6:0]    want;
  logic [6:0]    n_rd;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(SPAN - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
    return (p >= PW'(CAPACITY)) ? AW'(p - PW'(CAPACITY)) : AW'(p);
  endfunction

  always_comb begin
    accept = start && !busy;

    // committed minus read, modulo the pointer span
    if (cm_ptr >= rd_ptr) begin
      occ = cm_ptr - rd_ptr;
    end else begin
      occ = PW'(({1'b0, cm_ptr} + (PW+1)'(SPAN)) - {1'b0, rd_ptr});
    end
    space   = PW'(CAPACITY) - occ;
    too_big = CW'(cmd.block_count) > CW'(space);

    drop_sum  = {1'b0, drop_cnt} + 33'(cmd.block_count);
    drop_next = drop_sum[32] ? '1 : drop_sum[31:0];

    run_time_next = run_time + {32'b0, period};

    if (cmd.read_max == '0) begin
      want = 7'd1;
    end else if (cmd.read_max > 7'(MAX_READ)) begin
      want = 7'(MAX_READ);
    end else begin
      want = cmd.read_max;
    end
    n_rd = (NW'(occ) < NW'(want)) ? 7'(occ) : want;
  end

  assign busy = (state != ST_IDLE);

  assign wr_en    = accept && (cmd.kind == tsf_pkg::KIND_SAMPLE) && (blk_left != '0)
                    && !blk_drop;
  assign wr_addr  = ptr_slot(wr_ptr);
  assign wr_value = cmd.sample_value;
  assign wr_time  = run_time_next;

  assign rd_en   = (state == ST_READ);
  assign rd_addr = ptr_slot(rd_ptr);

  assign avail           = resp.from_ram ? 11'(rd_avail) : 11'(occ);
  assign dropped_total   = drop_cnt;
  assign last_block_size = blk_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wr_ptr   <= '0;
      cm_ptr   <= '0;
      rd_ptr   <= '0;
      blk_left <= '0;
      blk_drop <= 1'b0;
      run_time <= '0;
      drop_cnt <= '0;
      blk_size <= '0;
      period   <= tsf_pkg::PERIOD_RESET;
      rd_left  <= '0;
      rd_avail <= '0;
      resp     <= '0;
    end else begin
      resp <= '0;
      if (cfg_wr_en) begin
        period <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd.kind)
              tsf_pkg::KIND_HEADER: begin
                // an unfinished block is abandoned here
                blk_size <= cmd.block_count;
                blk_left <= cmd.block_count;
                wr_ptr   <= cm_ptr;
                if (too_big) begin
                  drop_cnt <= drop_next;
                  blk_drop <= 1'b1;
                  resp     <= '{strobe: 1'b1, from_ram: 1'b0,
                                status: tsf_pkg::STAT_DROPPED, last: 1'b1};
                end else begin
                  blk_drop <= 1'b0;
                  run_time <= cmd.start_time;
                  resp     <= '{strobe: 1'b1, from_ram: 1'b0,
                                status: tsf_pkg::STAT_ACCEPTED, last: 1'b1};
                end
              end
              tsf_pkg::KIND_SAMPLE: begin
                if (blk_left != '0) begin
                  blk_left <= blk_left - 16'd1;
                  if (!blk_drop) begin
                    run_time <= run_time_next;
                    wr_ptr   <= ptr_next(wr_ptr);
                    if (blk_left == 16'd1) begin
                      cm_ptr <= ptr_next(wr_ptr);
                    end
                  end
                end
              end
              tsf_pkg::KIND_READ: begin
                if (occ == '0) begin
                  resp <= '{strobe: 1'b1, from_ram: 1'b0,
                            status: tsf_pkg::STAT_EMPTY, last: 1'b1};
                end else begin
                  rd_left  <= n_rd;
                  rd_avail <= occ - PW'(n_rd);
                  state    <= ST_READ;
                end
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          // one RAM read per cycle, data shows on the result port next cycle
          rd_ptr  <= ptr_next(rd_ptr);
          rd_left <= rd_left - 7'd1;
          resp    <= '{strobe: 1'b1, from_ram: 1'b1,
                       status: tsf_pkg::STAT_SAMPLE, last: (rd_left == 7'd1)};
          if (rd_left == 7'd1) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TSF_CHECK(a_occ_bound, 1'b1, occ <= PW'(CAPACITY), "occupancy above capacity")
  `TSF_CHECK(a_read_nonempty, state == ST_READ, cm_ptr != rd_ptr, "read from empty queue")
  `TSF_CHECK_NEXT(a_read_ends, (state == ST_READ) && (rd_left == 7'd1), state == ST_IDLE, "read did not finish")
  `TSF_CHECK_NEXT(a_hdr_result, accept && (cmd.kind == tsf_pkg::KIND_HEADER), resp.strobe && resp.last && !resp.from_ram, "header gave no result")

endmodule

[rtl/core/timestamped_sample_fifo_top.sv]
// ----------------------------------------------------------------------------
// Timestamped sample FIFO - top level
// Sample queue with per-sample time stamps and whole-block admission.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on cmd, taken when start is high and busy is low.
//   Headers, samples and reads share the one command channel.
//   A header gives one result in the cycle after it is taken.
//   A sample gives no result; samples stream back to back.
//   A read of n samples holds busy while it issues one RAM read per cycle;
//   its results follow one per cycle, the first once the read state and the
//   registered RAM read data are passed, the last marked by last. An empty
//   read gives one status result in the cycle after it is taken.
//   Results show for one cycle, marked by result_stb; the receiver cannot
//   stall, so each transfer completes in that cycle.
//   sample_period is written via cfg_wr_en / cfg_wr_data, by the user only
//   while idle (not enforced). Reset empties the queue, clears the drop
//   total and block size, restores the default sample period; RAM is kept.
// ----------------------------------------------------------------------------
module timestamped_sample_fifo_top #(
  parameter int CAPACITY = tsf_pkg::CAPACITY_DEF,
  parameter int MAX_READ = tsf_pkg::MAX_READ_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tsf_pkg::in_item_t  cmd,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  output logic               result_stb,
  output tsf_pkg::out_item_t result
);

  localparam int AW = $clog2(CAPACITY);

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [31:0]    wr_value;
  logic [63:0]    wr_time;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [31:0]    rd_value;
  logic [63:0]    rd_time;
  tsf_pkg::resp_t resp;
  logic [10:0]    avail;
  logic [31:0]    dropped_total;
  logic [15:0]    last_block_size;

  tsf_ctrl #(
    .CAPACITY(CAPACITY),
    .MAX_READ(MAX_READ)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_value       (wr_value),
    .wr_time        (wr_time),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .resp           (resp),
    .avail          (avail),
    .dropped_total  (dropped_total),
    .last_block_size(last_block_size)
  );

  tsf_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_value_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_value)
  );

  tsf_ram #(
    .WIDTH(64),
    .DEPTH(CAPACITY)
  ) u_time_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_time),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_time)
  );

  // status-only results carry zero sample and stamp
  always_comb begin
    result_stb             = resp.strobe;
    result.status          = resp.status;
    result.sample_out      = resp.from_ram ? rd_value : '0;
    result.sample_time     = resp.from_ram ? rd_time : '0;
    result.last            = resp.last;
    result.available       = avail;
    result.dropped_total   = dropped_total;
    result.last_block_size = last_block_size;
  end

endmodule
